// ===== sv/wtbl_pkg.sv =====
// Shared types, constants and helpers of the wrapping token-bucket limiter.
// Used by the channel interfaces and by every module of the block.
package wtbl_pkg;

  localparam int WRAP_LIMIT = 2000000;
  localparam int FRAC_BITS = 16;
  localparam int CW = 37;
  localparam int TW = 11;
  localparam int LW = CW + 2;
  localparam int ADDR_W = 5;
  localparam int PDATA_W = 64;
  localparam int CNT_W = $clog2(CW + 1);

  localparam longint unsigned MOD_L = longint'(WRAP_LIMIT) << FRAC_BITS;
  localparam logic [CW-1:0] MODULUS = CW'(MOD_L);
  localparam logic [CW-1:0] DEFAULT_RATE = CW'(longint'(300) << FRAC_BITS);

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_RATE   = 2'd1,
    REG_TICKS  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic          enable;
    logic [CW-1:0] rate;
    logic [TW-1:0] ticks_per_interval;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Subtracts the modulus once when the value lies above it.
  function automatic logic [CW-1:0] wrap_once(input logic [CW:0] v);
    logic [CW:0] d;
    d = v - {1'b0, MODULUS};
    return (v > {1'b0, MODULUS}) ? d[CW-1:0] : v[CW-1:0];
  endfunction

endpackage

// ===== sv/wtbl_ifs.sv =====
// Request and response channel interfaces of the token-bucket limiter.
// Depends on wtbl_pkg for the credit width.
interface wtbl_req_if import wtbl_pkg::*;;
  logic          valid;
  logic          ready;
  logic          action;
  logic [CW-1:0] amount;

  modport source (output valid, action, amount, input ready);
  modport sink (input valid, action, amount, output ready);
endinterface

interface wtbl_rsp_if import wtbl_pkg::*;;
  logic          valid;
  logic          ready;
  logic [CW-1:0] granted;
  logic          fully_granted;
  logic [CW-1:0] measured_speed;

  modport source (output valid, granted, fully_granted, measured_speed, input ready);
  modport sink (input valid, granted, fully_granted, measured_speed, output ready);
endinterface

// ===== sv/wtbl_regs.sv =====
// APB-style configuration registers of the token-bucket limiter.
// Depends on wtbl_pkg for the register map and the cfg_t bundle.
module wtbl_regs import wtbl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_index_t idx;
  logic       wr;

  assign idx = reg_index_t'(paddr[4:3]);
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.rate <= DEFAULT_RATE;
      cfg.ticks_per_interval <= TW'(1);
    end else if (wr) begin
      unique case (idx)
        REG_ENABLE: cfg.enable <= pwdata[0];
        REG_RATE:   cfg.rate <= pwdata[CW-1:0];
        REG_TICKS:  cfg.ticks_per_interval <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, cfg.enable};
      REG_RATE:   prdata = {{(PDATA_W-CW){1'b0}}, cfg.rate};
      REG_TICKS:  prdata = {{(PDATA_W-TW){1'b0}}, cfg.ticks_per_interval};
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== sv/wtbl_divider.sv =====
// Iterative restoring divider: one quotient bit per cycle.
// Depends on wtbl_pkg for widths and the div_status_t bundle.
module wtbl_divider import wtbl_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [CW-1:0] dividend,
  input  logic [TW-1:0] divisor,
  output div_status_t   status,
  output logic [CW-1:0] quotient
);

  logic [CW-1:0]    quo;
  logic [TW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [TW:0]      rem_sh;
  logic [TW:0]      rem_sub;
  logic             fits;

  assign rem_sh = {rem, quo[CW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(CW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[CW-2:0], fits};
      rem <= fits ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient = quo;

endmodule

// ===== sv/wrapping_token_bucket_limiter_unit.sv =====
// Top level of the wrapping token-bucket rate limiter.
// Depends on wtbl_pkg, wtbl_ifs, wtbl_regs and wtbl_divider.
//
// Requests arrive on req: action 0 is a production tick, action 1 asks for
// amount of credit. Each request yields exactly one response on rsp with the
// granted credit, a fully-granted flag and the last measured speed.
// The block takes one request at a time; req.ready is high only while it is
// idle. A consume request passes the consume and grant states before its
// response is loaded into the output register; a request on a disabled
// block or a tick with a tick count of zero goes straight to the done state.
// An enabled tick divides the rate by the tick count in the serial divider,
// one quotient bit a cycle, then adds, trims and wraps the produced credit.
// The next request is accepted from the cycle after the response is loaded,
// even while it waits in the output register; if the receiver stalls, the
// next response waits until that register frees. Configuration is to be
// written over the APB port only while the block is idle, which the block
// does not enforce. Synchronous reset clears all credit counters, the tick
// phase and speed, disables limiting, loads the default rate and tick count 1.
module wrapping_token_bucket_limiter_unit import wtbl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  wtbl_req_if.sink           req,
  wtbl_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TICK  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_ADD   = 9'b000001000,
    S_TRIM  = 9'b000010000,
    S_WRAP  = 9'b000100000,
    S_CONS  = 9'b001000000,
    S_GRANT = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t          state;
  cfg_t            cfg;
  div_status_t     div_stat;
  logic [CW-1:0]   quotient;

  logic [CW-1:0]   prod;
  logic [CW-1:0]   cons;
  logic [CW-1:0]   isc;
  logic [TW-1:0]   phase;
  logic [CW-1:0]   speed;

  logic [CW-1:0]   amount;
  logic [CW-1:0]   inc;
  logic [CW:0]     sum;
  logic [CW:0]     avail;
  logic            avail_big;
  logic            no_credit;
  logic [CW-1:0]   res_granted;
  logic            res_full;

  logic            rsp_valid;
  logic [CW-1:0]   rsp_granted;
  logic            rsp_full;
  logic [CW-1:0]   rsp_speed;

  logic [CW-1:0]   r_clamp;
  logic [LW-1:0]   thr;
  logic [TW:0]     next_phase;
  logic            interval_end;
  logic [CW:0]     speed_wrap;
  logic [CW-1:0]   speed_new;
  logic            lead_over;
  logic [LW-1:0]   lead;
  logic            cons_lead;
  logic [LW-1:0]   cons_ahead;
  logic [LW-1:0]   wrap_av;
  logic            div_start;
  logic            out_free;

  wtbl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wtbl_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (r_clamp),
    .divisor  (cfg.ticks_per_interval),
    .status   (div_stat),
    .quotient (quotient)
  );

  assign req.ready = (state == S_IDLE);
  assign div_start = (state == S_TICK);
  assign out_free = !rsp_valid || rsp.ready;

  always_comb begin
    r_clamp = (cfg.rate > MODULUS) ? MODULUS : cfg.rate;
    thr = {2'b0, r_clamp} + {1'b0, r_clamp, 1'b0};
    next_phase = {1'b0, phase} + (TW+1)'(1);
    interval_end = next_phase >= ({1'b0, cfg.ticks_per_interval} + (TW+1)'(1));
    speed_wrap = {1'b0, cons} + {1'b0, MODULUS} - {1'b0, isc};
    speed_new = (cons < isc) ? speed_wrap[CW-1:0] : (cons - isc);
    lead = {1'b0, sum} - {2'b0, cons};
    lead_over = (sum > {1'b0, cons}) && (lead > thr);
    cons_ahead = {2'b0, cons} - {2'b0, prod};
    cons_lead = (cons > prod) && (cons_ahead > thr);
    wrap_av = {2'b0, prod} + {2'b0, MODULUS} - {2'b0, cons};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prod <= '0;
      cons <= '0;
      isc <= '0;
      phase <= '0;
      speed <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && !(state == S_DONE && out_free)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            amount <= req.amount;
            if (!req.action) begin
              res_granted <= '0;
              res_full <= 1'b0;
              if (cfg.enable && (cfg.ticks_per_interval != '0)) begin
                state <= S_TICK;
              end else begin
                state <= S_DONE;
              end
            end else if (!cfg.enable) begin
              res_granted <= req.amount;
              res_full <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_CONS;
            end
          end
        end
        S_TICK: begin
          if (interval_end) begin
            speed <= speed_new;
            isc <= wrap_once({1'b0, cons});
            phase <= TW'(1);
            if (prod > cons) begin
              prod <= cons;
            end
          end else begin
            if (next_phase == (TW+1)'(1)) begin
              isc <= wrap_once({1'b0, cons});
            end
            phase <= next_phase[TW-1:0];
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            inc <= quotient;
            state <= S_ADD;
          end
        end
        S_ADD: begin
          sum <= {1'b0, prod} + {1'b0, inc};
          state <= S_TRIM;
        end
        S_TRIM: begin
          if (lead_over) begin
            sum <= sum - {1'b0, inc};
          end
          state <= S_WRAP;
        end
        S_WRAP: begin
          prod <= wrap_once(sum);
          state <= S_DONE;
        end
        S_CONS: begin
          if (cons_lead) begin
            avail <= wrap_av[CW:0];
            avail_big <= wrap_av[LW-1];
            no_credit <= 1'b0;
          end else if (prod >= cons) begin
            avail <= {1'b0, prod - cons};
            avail_big <= 1'b0;
            no_credit <= 1'b0;
          end else begin
            avail_big <= 1'b0;
            no_credit <= 1'b1;
          end
          state <= S_GRANT;
        end
        S_GRANT: begin
          if (no_credit) begin
            res_granted <= '0;
            res_full <= (amount == '0);
          end else if (avail_big || (avail >= {1'b0, amount})) begin
            cons <= wrap_once({1'b0, cons} + {1'b0, amount});
            res_granted <= amount;
            res_full <= 1'b1;
          end else begin
            cons <= prod;
            res_granted <= avail[CW-1:0];
            res_full <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp_granted <= res_granted;
            rsp_full <= res_full;
            rsp_speed <= speed;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.granted = rsp_granted;
  assign rsp.fully_granted = rsp_full;
  assign rsp.measured_speed = rsp_speed;

`ifndef SYNTHESIS
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == S_DIV)
    else $error("Divider busy outside the divide step.");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (rsp_valid && state == S_IDLE))
    else $error("Finished response was not loaded into the output register.");

  a_phase_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && $past(state == S_TICK)) |-> phase != '0)
    else $error("Tick phase is zero after a tick.");

  a_wrap_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRAP) |=> prod <= MODULUS || $past(sum) > {1'b0, MODULUS} + {1'b0, MODULUS})
    else $error("Produced credit exceeds the modulus after wrapping.");
`endif

endmodule
